>>> sv/idfc_pkg.sv
// Shared types and constants for the ICMP drop flow counter.
package idfc_pkg;

    localparam int TABLE_ENTRIES_DEF = 256;

    localparam logic [15:0] ETHER_HDR_BYTES = 16'd14;
    localparam logic [15:0] IPV4_MIN_BYTES  = 16'd34;
    localparam logic [15:0] ETHER_IPV4      = 16'h0800;
    localparam logic [7:0]  PROTO_ICMP      = 8'd1;

    localparam logic [31:0] PKT_MAX  = 32'hFFFF_FFFF;
    localparam logic [47:0] BYTE_MAX = 48'hFFFF_FFFF_FFFF;

    localparam logic [1:0] VERDICT_PASS  = 2'd0;
    localparam logic [1:0] VERDICT_DROP  = 2'd1;
    localparam logic [1:0] VERDICT_ABORT = 2'd2;

    typedef struct packed {
        logic [15:0] frame_length;
        logic [15:0] ether_type;
        logic [7:0]  ip_protocol;
        logic [31:0] src_address;
        logic [31:0] dst_address;
    } t_item;

    typedef struct packed {
        logic [1:0]  verdict;
        logic        flow_recorded;
        logic [31:0] flow_packets;
        logic [47:0] flow_bytes;
    } t_result;

    // counter store commands from the sequencer
    typedef struct packed {
        logic rd_en;
        logic new_en;
        logic upd_en;
    } t_cnt_cmd;

endpackage

>>> sv/icmp_drop_flow_counter.sv
// Top level: frame classification, flow table scan sequencer and result register.
//
//   channel | signals                  | handshake
//   --------+--------------------------+---------------------------------------
//   item    | start, i_item, busy      | taken when start is high, busy low
//   result  | o_valid, o_result        | one-cycle strobe, always taken
//
// Pass and aborted frames report from the idle state; the next item can start right away.
// A dropped frame scans the key memory one entry a cycle (registered read):
// a hit moves to the update state, which writes the counters and reports; a new or
// unrecorded flow reports from the scan state once every used entry is compared.
// Entries fill in index order, so the fill count marks valid entries; no clear pass.
// Reset is synchronous; the result strobe cannot be stalled.
module icmp_drop_flow_counter #(
    parameter int TABLE_ENTRIES = idfc_pkg::TABLE_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  idfc_pkg::t_item   i_item,
    output logic              busy,
    output logic              o_valid,
    output idfc_pkg::t_result o_result
);
    import idfc_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPDATE} t_state;

    t_state           r_state;
    t_item            r_item;
    logic [CNT_W-1:0] r_used;
    logic [CNT_W-1:0] r_idx;
    logic             r_rd_pend;
    logic [IDX_W-1:0] r_rd_idx;
    logic [IDX_W-1:0] r_slot;
    logic             r_valid;
    t_result          r_result;

    logic [1:0]       in_verdict;
    logic [63:0]      key;
    logic [63:0]      rd_key;
    logic             issue;
    logic             hit;
    logic             miss;
    logic             table_full;
    logic             scanning;
    t_cnt_cmd         cnt_cmd;
    logic [IDX_W-1:0] cnt_addr;
    logic [31:0]      cnt_packets;
    logic [47:0]      cnt_bytes;

    always_comb begin
        if (i_item.frame_length < ETHER_HDR_BYTES) begin
            in_verdict = VERDICT_ABORT;
        end else if (i_item.ether_type != ETHER_IPV4) begin
            in_verdict = VERDICT_PASS;
        end else if (i_item.frame_length < IPV4_MIN_BYTES) begin
            in_verdict = VERDICT_ABORT;
        end else if (i_item.ip_protocol != PROTO_ICMP) begin
            in_verdict = VERDICT_PASS;
        end else begin
            in_verdict = VERDICT_DROP;
        end
    end

    assign key        = {r_item.src_address, r_item.dst_address};
    assign scanning   = (r_state == S_SCAN);
    assign issue      = (r_idx != r_used);
    assign hit        = r_rd_pend && (rd_key == key);
    // everything issued and compared, no match
    assign miss       = !hit && !issue && !r_rd_pend;
    assign table_full = (r_used == FULL_COUNT);

    always_comb begin
        cnt_cmd.rd_en  = scanning && hit;
        cnt_cmd.new_en = scanning && miss && !table_full;
        cnt_cmd.upd_en = (r_state == S_UPDATE);
        if (r_state == S_UPDATE) begin
            cnt_addr = r_slot;
        end else if (hit) begin
            cnt_addr = r_rd_idx;
        end else begin
            cnt_addr = r_used[IDX_W-1:0];
        end
    end

    idfc_key_mem #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_key_mem (
        .i_clk     (i_clk),
        .i_wr_en   (cnt_cmd.new_en),
        .i_wr_addr (r_used[IDX_W-1:0]),
        .i_wr_key  (key),
        .i_rd_en   (scanning && issue),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_key  (rd_key)
    );

    idfc_cnt_unit #(
        .ENTRIES (TABLE_ENTRIES),
        .IDX_W   (IDX_W)
    ) u_cnt_unit (
        .i_clk     (i_clk),
        .i_cmd     (cnt_cmd),
        .i_addr    (cnt_addr),
        .i_len     (r_item.frame_length),
        .o_packets (cnt_packets),
        .o_bytes   (cnt_bytes)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= '0;
            r_idx     <= '0;
            r_rd_pend <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_item <= i_item;
                        if (in_verdict == VERDICT_DROP) begin
                            r_state   <= S_SCAN;
                            r_idx     <= '0;
                            r_rd_pend <= 1'b0;
                        end else begin
                            r_valid  <= 1'b1;
                            r_result <= '{verdict: in_verdict, flow_recorded: 1'b0,
                                          flow_packets: 32'd0, flow_bytes: 48'd0};
                        end
                    end
                end
                S_SCAN: begin
                    r_rd_pend <= issue && !hit;
                    r_rd_idx  <= r_idx[IDX_W-1:0];
                    if (issue && !hit) begin
                        r_idx <= r_idx + CNT_W'(1);
                    end
                    if (hit) begin
                        r_slot  <= r_rd_idx;
                        r_state <= S_UPDATE;
                    end else if (miss) begin
                        r_state <= S_IDLE;
                        r_valid <= 1'b1;
                        if (table_full) begin
                            r_result <= '{verdict: VERDICT_DROP, flow_recorded: 1'b0,
                                          flow_packets: 32'd0, flow_bytes: 48'd0};
                        end else begin
                            r_used   <= r_used + CNT_W'(1);
                            r_result <= '{verdict: VERDICT_DROP, flow_recorded: 1'b1,
                                          flow_packets: cnt_packets, flow_bytes: cnt_bytes};
                        end
                    end
                end
                S_UPDATE: begin
                    r_state  <= S_IDLE;
                    r_valid  <= 1'b1;
                    r_result <= '{verdict: VERDICT_DROP, flow_recorded: 1'b1,
                                  flow_packets: cnt_packets, flow_bytes: cnt_bytes};
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

>>> sv/idfc_key_mem.sv
// Flow key memory: one write port, one registered read port.
module idfc_key_mem #(
    parameter int ENTRIES = idfc_pkg::TABLE_ENTRIES_DEF,
    parameter int IDX_W   = 8
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  logic [63:0]      i_wr_key,
    input  logic             i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output logic [63:0]      o_rd_key
);
    logic [63:0] r_mem [ENTRIES];
    logic [63:0] r_rd_key;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_key;
        end
        if (i_rd_en) begin
            r_rd_key <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_key = r_rd_key;

endmodule

>>> sv/idfc_cnt_unit.sv
// Counter store with the saturating packet and byte update unit.
module idfc_cnt_unit #(
    parameter int ENTRIES = idfc_pkg::TABLE_ENTRIES_DEF,
    parameter int IDX_W   = 8
) (
    input  logic                i_clk,
    input  idfc_pkg::t_cnt_cmd  i_cmd,
    input  logic [IDX_W-1:0]    i_addr,
    input  logic [15:0]         i_len,
    output logic [31:0]         o_packets,
    output logic [47:0]         o_bytes
);
    import idfc_pkg::*;

    logic [31:0] r_pkt_mem  [ENTRIES];
    logic [47:0] r_byte_mem [ENTRIES];
    logic [31:0] r_pkt_q;
    logic [47:0] r_byte_q;

    logic [48:0] byte_sum;
    logic [31:0] upd_packets;
    logic [47:0] upd_bytes;

    always_comb begin
        byte_sum = {1'b0, r_byte_q} + {33'd0, i_len};
        if (i_cmd.new_en) begin
            upd_packets = 32'd1;
            upd_bytes   = {32'd0, i_len};
        end else begin
            upd_packets = (r_pkt_q == PKT_MAX) ? r_pkt_q : r_pkt_q + 32'd1;
            upd_bytes   = byte_sum[48] ? BYTE_MAX : byte_sum[47:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_pkt_q  <= r_pkt_mem[i_addr];
            r_byte_q <= r_byte_mem[i_addr];
        end
        if (i_cmd.new_en || i_cmd.upd_en) begin
            r_pkt_mem[i_addr]  <= upd_packets;
            r_byte_mem[i_addr] <= upd_bytes;
        end
    end

    assign o_packets = upd_packets;
    assign o_bytes   = upd_bytes;

endmodule

>>> sv/idfc_checker.sv
// Port-level checks for the ICMP drop flow counter, bound to the top level.
module idfc_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_valid,
    input idfc_pkg::t_result o_result
);
    import idfc_pkg::*;

    // every accepted word either reports at once or starts a table walk
    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> o_valid || busy)
        else $error("accepted item neither reported nor in progress");

    a_done_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> o_valid)
        else $error("table walk ended without a result");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_nondrop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.verdict != VERDICT_DROP |->
            !o_result.flow_recorded && o_result.flow_packets == 32'd0
            && o_result.flow_bytes == 48'd0)
        else $error("pass or abort carries flow counters");

    a_recorded_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.flow_recorded |->
            o_result.verdict == VERDICT_DROP && o_result.flow_packets != 32'd0)
        else $error("recorded flow with bad verdict or zero packets");

endmodule

bind icmp_drop_flow_counter idfc_checker u_idfc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);
